>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/glu_pkg.sv
// Package for the GCD/LCM unit: widths, micro-op codes and the control store.
package glu_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int IN_W          = 32;
    localparam int DIV_W         = 31;
    localparam int MUL_W         = 62;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int K_W           = $clog2(OPERAND_WIDTH);
    localparam int CNT_W         = $clog2(OPERAND_WIDTH + 1);
    localparam int UPC_W         = 3;

    localparam logic [63:0] WIDE_LIMIT = 64'd2147483647;
    localparam logic [31:0] DIV_LIMIT  = 32'h7FFF_FFFF;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_GCD,
        OP_GFIN,
        OP_DIV,
        OP_MUL,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,      // fall through
        C_ALWAYS,    // unconditional jump
        C_NO_IN,     // jump while no beat accepted
        C_ZERO,      // jump if an operand is zero
        C_UNEQUAL,   // jump while gcd operands differ
        C_CNT_MORE,  // jump while division steps remain
        C_OUT_BUSY   // jump while the result register cannot take a beat
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    localparam upc_t ST_LOAD = 3'd0;
    localparam upc_t ST_ZCHK = 3'd1;
    localparam upc_t ST_GCD  = 3'd2;
    localparam upc_t ST_GFIN = 3'd3;
    localparam upc_t ST_DIV  = 3'd4;
    localparam upc_t ST_MUL  = 3'd5;
    localparam upc_t ST_EMIT = 3'd6;
    localparam upc_t ST_WRAP = 3'd7;

    // Control store: one word per step.
    function automatic ctrl_word_t ucode_rom(input upc_t upc);
        ctrl_word_t w;
        unique case (upc)
            ST_LOAD: w = '{op: OP_LOAD, cond: C_NO_IN,    target: ST_LOAD};
            ST_ZCHK: w = '{op: OP_NOP,  cond: C_ZERO,     target: ST_EMIT};
            ST_GCD:  w = '{op: OP_GCD,  cond: C_UNEQUAL,  target: ST_GCD};
            ST_GFIN: w = '{op: OP_GFIN, cond: C_NEXT,     target: ST_LOAD};
            ST_DIV:  w = '{op: OP_DIV,  cond: C_CNT_MORE, target: ST_DIV};
            ST_MUL:  w = '{op: OP_MUL,  cond: C_NEXT,     target: ST_LOAD};
            ST_EMIT: w = '{op: OP_EMIT, cond: C_OUT_BUSY, target: ST_EMIT};
            ST_WRAP: w = '{op: OP_NOP,  cond: C_ALWAYS,   target: ST_LOAD};
            default: w = '{op: OP_NOP,  cond: C_ALWAYS,   target: ST_LOAD};
        endcase
        return w;
    endfunction

    // Magnitude of the low OPERAND_WIDTH bits read as two's complement.
    function automatic logic [OPERAND_WIDTH-1:0] magnitude(input logic [IN_W-1:0] raw);
        logic [OPERAND_WIDTH-1:0] v;
        v = raw[OPERAND_WIDTH-1:0];
        return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

>>> rtl/gcd_lcm_unit.sv
// GCD/LCM unit top level: microcoded sequencer and its datapath.
//
// Takes one beat of two signed operands and returns one beat holding the
// greatest common divisor and the least common multiple of their magnitudes.
// The divisor is found with the binary (Stein) method, one subtract-and-halve
// step a cycle; the multiple is (|a| / gcd) * |b|, using a restoring divider
// that retires one quotient bit a cycle and a single registered multiply.
// An operand of zero gives zero_error with all results zero. The divisor
// saturates at 2^31-1; the multiple is exact, and wide_flag marks one above
// 2^31-1. One beat is in flight at a time: in_stall is low only while the
// sequencer waits at its first step. How long a beat takes is set by the gcd
// loop, which takes one step per bit shed from either operand, and by the
// divider, both driven by the control store in glu_pkg; a zero operand skips
// both. A finished result sits in the output register, so the next beat's gcd
// loop is not held up by a stalled receiver until it has to be emitted.
module gcd_lcm_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [glu_pkg::IN_W-1:0] first_value,
    input  logic signed [glu_pkg::IN_W-1:0] second_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [glu_pkg::DIV_W-1:0]     divisor_result,
    output logic [glu_pkg::MUL_W-1:0]     multiple_result,
    output logic                          wide_flag,
    output logic                          zero_error
);

    localparam int W = glu_pkg::OPERAND_WIDTH;

    // Sequencer
    glu_pkg::upc_t       upc_reg, upc_next;
    glu_pkg::ctrl_word_t uw;
    logic                jump;
    logic                in_fire;
    logic                emit_ok;

    // Datapath
    logic [W-1:0]                a_reg, a_next;
    logic [W-1:0]                b_reg, b_next;
    logic [W-1:0]                x_reg, x_next;
    logic [W-1:0]                y_reg, y_next;
    logic [glu_pkg::K_W-1:0]     k_reg, k_next;
    logic [W-1:0]                g_reg, g_next;
    logic [W-1:0]                rem_reg, rem_next;
    logic [W-1:0]                quo_reg, quo_next;
    logic [glu_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [glu_pkg::PROD_W-1:0]  prod_reg, prod_next;

    // Result register
    logic                        out_valid_reg, out_valid_next;
    logic [glu_pkg::DIV_W-1:0]   divisor_reg, divisor_next;
    logic [glu_pkg::MUL_W-1:0]   multiple_reg, multiple_next;
    logic                        wide_reg, wide_next;
    logic                        zero_reg, zero_next;

    logic                        any_zero;
    logic [W:0]                  shifted;
    logic [W+1:0]                trial;

    assign uw       = glu_pkg::ucode_rom(upc_reg);
    assign in_stall = (upc_reg != glu_pkg::ST_LOAD);
    assign in_fire  = in_valid && !in_stall;
    assign emit_ok  = !out_valid_reg || !out_stall;
    assign any_zero = (a_reg == '0) || (b_reg == '0);

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, g_reg};

    // Next step: jump to the word's target when its condition holds.
    always_comb
    begin
        unique case (uw.cond)
            glu_pkg::C_NEXT:     jump = 1'b0;
            glu_pkg::C_ALWAYS:   jump = 1'b1;
            glu_pkg::C_NO_IN:    jump = !in_fire;
            glu_pkg::C_ZERO:     jump = any_zero;
            glu_pkg::C_UNEQUAL:  jump = (x_reg != y_reg);
            glu_pkg::C_CNT_MORE: jump = (cnt_reg != glu_pkg::CNT_W'(1));
            glu_pkg::C_OUT_BUSY: jump = !emit_ok;
            default:             jump = 1'b1;
        endcase
        upc_next = jump ? uw.target : upc_reg + 1'b1;
    end

    // Datapath operations selected by the control word.
    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        divisor_next   = divisor_reg;
        multiple_next  = multiple_reg;
        wide_next      = wide_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (uw.op)
            glu_pkg::OP_NOP:
            begin
            end
            glu_pkg::OP_LOAD:
            begin
                if (in_fire)
                begin
                    a_next = glu_pkg::magnitude(first_value);
                    b_next = glu_pkg::magnitude(second_value);
                    x_next = glu_pkg::magnitude(first_value);
                    y_next = glu_pkg::magnitude(second_value);
                    k_next = '0;
                end
            end
            glu_pkg::OP_GCD:
            begin
                // one Stein step; idle once the operands meet
                if (x_reg != y_reg)
                begin
                    priority if (!x_reg[0] && !y_reg[0])
                    begin
                        x_next = x_reg >> 1;
                        y_next = y_reg >> 1;
                        k_next = k_reg + 1'b1;
                    end
                    else if (!x_reg[0])
                        x_next = x_reg >> 1;
                    else if (!y_reg[0])
                        y_next = y_reg >> 1;
                    else if (x_reg > y_reg)
                        x_next = (x_reg - y_reg) >> 1;
                    else
                        y_next = (y_reg - x_reg) >> 1;
                end
            end
            glu_pkg::OP_GFIN:
            begin
                g_next   = x_reg << k_reg;
                rem_next = '0;
                quo_next = a_reg;
                cnt_next = glu_pkg::CNT_W'(W);
            end
            glu_pkg::OP_DIV:
            begin
                // restoring step: quotient bit enters from the right
                if (!trial[W+1])
                begin
                    rem_next = trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            glu_pkg::OP_MUL:
            begin
                prod_next = glu_pkg::PROD_W'(quo_reg) * glu_pkg::PROD_W'(b_reg);
            end
            glu_pkg::OP_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    zero_next      = any_zero;
                    if (any_zero)
                    begin
                        divisor_next  = '0;
                        multiple_next = '0;
                        wide_next     = 1'b0;
                    end
                    else
                    begin
                        divisor_next  = (32'(g_reg) > glu_pkg::DIV_LIMIT) ?
                                        '1 : glu_pkg::DIV_W'(g_reg);
                        multiple_next = glu_pkg::MUL_W'(prod_reg);
                        wide_next     = (64'(prod_reg) > glu_pkg::WIDE_LIMIT);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= glu_pkg::ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        k_reg        <= k_next;
        g_reg        <= g_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        divisor_reg  <= divisor_next;
        multiple_reg <= multiple_next;
        wide_reg     <= wide_next;
        zero_reg     <= zero_next;
    end

    assign out_valid       = out_valid_reg;
    assign divisor_result  = divisor_reg;
    assign multiple_result = multiple_reg;
    assign wide_flag       = wide_reg;
    assign zero_error      = zero_reg;

endmodule

>>> rtl/glu_chk.sv
// Port-level checker for the GCD/LCM unit, bound to the top level.
`include "assert_macros.svh"

module glu_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [glu_pkg::IN_W-1:0]      first_value,
    input logic [glu_pkg::IN_W-1:0]      second_value,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [glu_pkg::DIV_W-1:0]     divisor_result,
    input logic [glu_pkg::MUL_W-1:0]     multiple_result,
    input logic                          wide_flag,
    input logic                          zero_error
);

    // a stalled operand beat holds
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(first_value) && $stable(second_value))

    // zero operand beat carries nothing else
    `ASSERT_IMPLY(a_zero_clean, clk, rst_n, out_valid && zero_error, divisor_result == '0 && multiple_result == '0 && !wide_flag)

    // wide flag tracks the multiple
    `ASSERT_IMPLY(a_wide_match, clk, rst_n, out_valid, wide_flag == (64'(multiple_result) > glu_pkg::WIDE_LIMIT))

    // lcm never below gcd, gcd never zero on a good beat
    `ASSERT_IMPLY(a_lcm_ge_gcd, clk, rst_n, out_valid && !zero_error, divisor_result != '0 && 64'(multiple_result) >= 64'(divisor_result))

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(multiple_result) && $stable(divisor_result))

endmodule

bind gcd_lcm_unit glu_chk u_glu_chk (.*);
